// ----- sv/bpu_pkg.sv -----
// Bitmap pixel unpacker package: register codes, depth and format codes,
// the request passed from the unpack stage to the format stage, and the pixel formatter.
// No dependencies.
package bpu_pkg;

    localparam int DEF_MAX_WIDTH       = 8192;
    localparam int DEF_PALETTE_ENTRIES = 256;

    localparam int CFG_DATA_W = 14;

    // Configuration register indexes
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_DEPTH_MODE    = 3'd0;
    localparam reg_idx_t REG_OUT_FORMAT    = 3'd1;
    localparam reg_idx_t REG_IMAGE_WIDTH   = 3'd2;
    localparam reg_idx_t REG_IMAGE_HEIGHT  = 3'd3;
    localparam reg_idx_t REG_ALPHA_DEFAULT = 3'd4;

    // Depth selector codes
    typedef logic [2:0] depth_mode_t;
    localparam depth_mode_t DEPTH_1BPP  = 3'd0;
    localparam depth_mode_t DEPTH_2BPP  = 3'd1;
    localparam depth_mode_t DEPTH_4BPP  = 3'd2;
    localparam depth_mode_t DEPTH_8BPP  = 3'd3;
    localparam depth_mode_t DEPTH_24BPP = 3'd4;
    localparam depth_mode_t DEPTH_32BPP = 3'd5;

    // Result format codes
    typedef logic [1:0] fmt_t;
    localparam fmt_t FMT_RGB32  = 2'd0;
    localparam fmt_t FMT_RGB24  = 2'd1;
    localparam fmt_t FMT_RGB565 = 2'd2;

    localparam logic [2:0] BYTES_RGB32  = 3'd4;
    localparam logic [2:0] BYTES_RGB24  = 3'd3;
    localparam logic [2:0] BYTES_RGB565 = 3'd2;

    // Request operation codes
    localparam logic OP_PAL_WRITE = 1'b0;
    localparam logic OP_DATA      = 1'b1;

    // Decoded depth: palette depths carry log2 of bits per pixel
    typedef struct packed {
        logic       pal;
        logic       is24;
        logic [1:0] lg;
    } depth_dec_t;

    // Geometry and alpha seen by the unpack stage
    typedef struct packed {
        depth_mode_t depth_mode;
        logic [13:0] image_width;
        logic [13:0] image_height;
        logic [7:0]  alpha_default;
    } unpack_cfg_t;

    // One pixel on its way to the formatter
    typedef struct packed {
        logic        pal;        // take the entry from palette read data
        logic        zero;       // index beyond the palette: all bytes zero
        logic [31:0] src;        // direct pixel: {a, s2, s1, s0}
        logic        row_end;
        logic        frame_end;
        logic        last;
    } pix_req_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  bytes;
    } pix_word_t;

    typedef struct packed {
        pix_word_t word;
        logic      row_end;
        logic      frame_end;
        logic      last;
    } out_item_t;

    function automatic depth_dec_t decode_depth(depth_mode_t mode);
        depth_dec_t d;
        d = '{pal: 1'b1, is24: 1'b0, lg: 2'd3};
        case (mode)
            DEPTH_1BPP:  d.lg = 2'd0;
            DEPTH_2BPP:  d.lg = 2'd1;
            DEPTH_4BPP:  d.lg = 2'd2;
            DEPTH_24BPP: d = '{pal: 1'b0, is24: 1'b1, lg: 2'd3};
            DEPTH_32BPP: d = '{pal: 1'b0, is24: 1'b0, lg: 2'd3};
            default:     d.lg = 2'd3;
        endcase
        return d;
    endfunction

    // e holds s0 in the low byte, then s1, s2 and alpha
    function automatic pix_word_t format_pixel(logic [31:0] e, fmt_t fmt);
        pix_word_t r;
        case (fmt)
            FMT_RGB24: begin
                r.value = {8'h00, e[7:0], e[15:8], e[23:16]};
                r.bytes = BYTES_RGB24;
            end
            FMT_RGB565: begin
                r.value = {16'h0000, e[7:3], e[15:10], e[23:19]};
                r.bytes = BYTES_RGB565;
            end
            default: begin
                r.value = {e[31:24], e[7:0], e[15:8], e[23:16]};
                r.bytes = BYTES_RGB32;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- sv/bpu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/bpu_unpack.sv -----
// Unpack stage: holds one request, tracks row position, issues one pixel per cycle while can_issue.
// Depends on bpu_pkg.
module bpu_unpack #(
    parameter int MAX_WIDTH       = 8192,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bpu_pkg::unpack_cfg_t               cfg,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic [7:0]                         palette_slot,
    input  logic [31:0]                        palette_word,
    input  logic [7:0]                         data_byte,
    output logic                               pal_we,
    output logic [$clog2(PALETTE_ENTRIES)-1:0] pal_waddr,
    output logic [31:0]                        pal_wdata,
    output logic                               pal_re,
    output logic [$clog2(PALETTE_ENTRIES)-1:0] pal_raddr,
    input  logic                               can_issue,
    output logic                               req_valid,
    output bpu_pkg::pix_req_t                  req
);
    import bpu_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int BITS_W = CNT_W + 5;
    localparam int RB_W   = CNT_W + 2;
    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    logic              a_valid_reg, a_valid_next;
    logic              a_op_reg;
    logic [7:0]        a_slot_reg;
    logic [31:0]       a_word_reg;
    logic [7:0]        a_byte_reg, a_byte_next;
    logic [2:0]        a_sub_reg, a_sub_next;
    logic [RB_W-1:0]   rbc_reg, rbc_next;
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [13:0]       row_reg, row_next;
    logic [23:0]       pp_reg, pp_next;
    logic [1:0]        pc_reg, pc_next;

    depth_dec_t        dec;
    logic [13:0]       iw_nz, h_eff;
    logic [CNT_W-1:0]  w_eff;
    logic [BITS_W-1:0] row_bits, row_bits_up;
    logic [RB_W-1:0]   stride;
    logic [RB_W:0]     rbc_inc;
    logic [CNT_W:0]    col_inc;
    logic [14:0]       row_inc;
    logic              col_ok, row_end, last_row, need_full, is_data, wants;
    logic [2:0]        sub_last;
    logic              last_pix, issue, step_done, data_done, wrap, accept;
    logic [7:0]        idx;
    logic [3:0]        bpp_amt;

    always_comb
    begin
        dec     = decode_depth(cfg.depth_mode);
        bpp_amt = 4'd1 << dec.lg;

        iw_nz = (cfg.image_width == 14'd0) ? 14'd1 : cfg.image_width;
        if (32'(iw_nz) > MAX_WIDTH)
        begin
            w_eff = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CNT_W'(iw_nz);
        end
        h_eff = (cfg.image_height == 14'd0) ? 14'd1 : cfg.image_height;

        // Row stride in bytes, rounded up to whole 32-bit words
        if (dec.pal)
        begin
            row_bits = BITS_W'(w_eff) << dec.lg;
        end
        else if (dec.is24)
        begin
            row_bits = (BITS_W'(w_eff) << 4) + (BITS_W'(w_eff) << 3);
        end
        else
        begin
            row_bits = BITS_W'(w_eff) << 5;
        end
        row_bits_up = row_bits + BITS_W'(31);
        stride      = RB_W'(row_bits_up >> 5) << 2;

        col_ok   = col_reg < w_eff;
        col_inc  = {1'b0, col_reg} + 1'b1;
        row_end  = col_inc >= {1'b0, w_eff};
        row_inc  = {1'b0, row_reg} + 15'd1;
        last_row = row_inc >= {1'b0, h_eff};

        need_full = dec.is24 ? (pc_reg >= 2'd2) : (pc_reg == 2'd3);
        is_data   = a_op_reg == OP_DATA;
        wants     = is_data && col_ok && (dec.pal || need_full);

        case (dec.lg)
            2'd0:    sub_last = 3'd7;
            2'd1:    sub_last = 3'd3;
            2'd2:    sub_last = 3'd1;
            default: sub_last = 3'd0;
        endcase
        last_pix = !dec.pal || (a_sub_reg == sub_last) || row_end;

        issue     = a_valid_reg && wants && can_issue;
        step_done = a_valid_reg && (!wants || (issue && last_pix));
        data_done = step_done && is_data;
        in_stall  = a_valid_reg && !step_done;
        accept    = in_valid && !in_stall;

        rbc_inc = {1'b0, rbc_reg} + 1'b1;
        wrap    = rbc_inc >= {1'b0, stride};

        // Sub-byte indices come from the top bits first
        case (dec.lg)
            2'd0:    idx = {7'b0, a_byte_reg[7]};
            2'd1:    idx = {6'b0, a_byte_reg[7:6]};
            2'd2:    idx = {4'b0, a_byte_reg[7:4]};
            default: idx = a_byte_reg;
        endcase

        pal_we    = a_valid_reg && !is_data && (32'(a_slot_reg) < PALETTE_ENTRIES);
        pal_waddr = a_slot_reg[PAL_AW-1:0];
        pal_wdata = a_word_reg;
        pal_re    = issue && dec.pal;
        pal_raddr = idx[PAL_AW-1:0];

        req_valid     = issue;
        req.pal       = dec.pal;
        req.zero      = 32'(idx) >= PALETTE_ENTRIES;
        req.src[7:0]  = pp_reg[7:0];
        req.src[15:8] = pp_reg[15:8];
        req.src[23:16] = dec.is24 ? a_byte_reg : pp_reg[23:16];
        req.src[31:24] = dec.is24 ? cfg.alpha_default : a_byte_reg;
        req.row_end   = row_end;
        req.frame_end = row_end && last_row;
        req.last      = last_pix;

        // Next state
        a_valid_next = accept ? 1'b1 : (step_done ? 1'b0 : a_valid_reg);
        a_byte_next  = a_byte_reg;
        a_sub_next   = a_sub_reg;
        if (accept)
        begin
            a_byte_next = data_byte;
            a_sub_next  = 3'd0;
        end
        else if (issue)
        begin
            a_byte_next = a_byte_reg << bpp_amt;
            a_sub_next  = a_sub_reg + 3'd1;
        end

        col_next = issue ? col_inc[CNT_W-1:0] : col_reg;
        rbc_next = rbc_reg;
        row_next = row_reg;
        pp_next  = pp_reg;
        pc_next  = pc_reg;
        if (data_done)
        begin
            if (issue && !dec.pal)
            begin
                pp_next = 24'd0;
                pc_next = 2'd0;
            end
            else if (!dec.pal && col_ok)
            begin
                case (pc_reg)
                    2'd0:    pp_next[7:0]   = a_byte_reg;
                    2'd1:    pp_next[15:8]  = a_byte_reg;
                    2'd2:    pp_next[23:16] = a_byte_reg;
                    default: pp_next        = pp_reg;
                endcase
                pc_next = pc_reg + 2'd1;
            end

            if (wrap)
            begin
                rbc_next = '0;
                col_next = '0;
                pp_next  = 24'd0;
                pc_next  = 2'd0;
                row_next = last_row ? 14'd0 : row_inc[13:0];
            end
            else
            begin
                rbc_next = rbc_inc[RB_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_sub_reg   <= 3'd0;
            rbc_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= 14'd0;
            pp_reg      <= 24'd0;
            pc_reg      <= 2'd0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            a_sub_reg   <= a_sub_next;
            rbc_reg     <= rbc_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pp_reg      <= pp_next;
            pc_reg      <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_byte_reg <= a_byte_next;
        if (accept)
        begin
            a_op_reg   <= operation;
            a_slot_reg <= palette_slot;
            a_word_reg <= palette_word;
        end
    end

endmodule

// ----- sv/bpu_format.sv -----
// Format stage: merges palette read data, formats the pixel, two-entry output queue.
// Depends on bpu_pkg.
module bpu_format (
    input  logic              clk,
    input  logic              rst_n,
    input  bpu_pkg::fmt_t     out_format,
    input  logic              req_valid,
    input  bpu_pkg::pix_req_t req,
    input  logic [31:0]       pal_rdata,
    output logic              can_issue,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       pixel_value,
    output logic [2:0]        pixel_bytes,
    output logic              row_end,
    output logic              frame_end,
    output logic              last_of_run
);
    import bpu_pkg::*;

    logic      b_valid_reg;
    pix_req_t  b_req_reg;
    out_item_t q_reg [2];
    logic [1:0] count_reg, count_next;
    logic      wr_ptr_reg, rd_ptr_reg;

    logic      push, pop;
    logic [31:0] entry;
    out_item_t item, head;

    always_comb
    begin
        entry = b_req_reg.pal ? (b_req_reg.zero ? 32'd0 : pal_rdata) : b_req_reg.src;
        item.word      = format_pixel(entry, out_format);
        item.row_end   = b_req_reg.row_end;
        item.frame_end = b_req_reg.frame_end;
        item.last      = b_req_reg.last;

        push = b_valid_reg;
        pop  = (count_reg != 2'd0) && !out_stall;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};

        // Room for the pixel in flight plus the one issued now
        can_issue = ({1'b0, count_reg} + {2'b0, b_valid_reg}) < (3'd2 + {2'b0, pop});

        head        = q_reg[rd_ptr_reg];
        out_valid   = count_reg != 2'd0;
        pixel_value = head.word.value;
        pixel_bytes = head.word.bytes;
        row_end     = head.row_end;
        frame_end   = head.frame_end;
        last_of_run = head.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            count_reg   <= 2'd0;
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
        end
        else
        begin
            b_valid_reg <= req_valid;
            count_reg   <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            b_req_reg <= req;
        end
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ----- sv/bitmap_pixel_unpacker_top.sv -----
// Bitmap pixel unpacker: an accepted data byte passes the unpack request register, the format
// request register and the output queue before its first pixel is offered. Throughput is one
// pixel per cycle while the output queue has room, set by the single palette read port: one byte
// per cycle at 8, 24 and 32 bpp; at 1, 2 and 4 bpp a byte is held until its pixels have issued.
// Reset clears row position, partial pixel and the output queue and restores register
// defaults; the palette RAM is not cleared and is undefined until written.
module bitmap_pixel_unpacker_top
    import bpu_pkg::*;
#(
    parameter int MAX_WIDTH       = bpu_pkg::DEF_MAX_WIDTH,
    parameter int PALETTE_ENTRIES = bpu_pkg::DEF_PALETTE_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  bpu_pkg::reg_idx_t             cfg_index,
    input  logic [bpu_pkg::CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [7:0]                    palette_slot,
    input  logic [31:0]                   palette_word,
    input  logic [7:0]                    data_byte,
    // pixel channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [31:0]                   pixel_value,
    output logic [2:0]                    pixel_bytes,
    output logic                          row_end,
    output logic                          frame_end,
    output logic                          last_of_run
);

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    // Configuration registers
    depth_mode_t depth_mode_reg;
    fmt_t        out_format_reg;
    logic [13:0] image_width_reg;
    logic [13:0] image_height_reg;
    logic [7:0]  alpha_default_reg;

    unpack_cfg_t       ucfg;
    logic              pal_we, pal_re, can_issue, req_valid;
    logic [PAL_AW-1:0] pal_waddr, pal_raddr;
    logic [31:0]       pal_wdata, pal_rdata;
    pix_req_t          req;

    // Take register writes at once; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg    <= DEPTH_8BPP;
            out_format_reg    <= FMT_RGB32;
            image_width_reg   <= 14'd1;
            image_height_reg  <= 14'd1;
            alpha_default_reg <= 8'hff;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEPTH_MODE:    depth_mode_reg    <= cfg_data[2:0];
                REG_OUT_FORMAT:    out_format_reg    <= cfg_data[1:0];
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[13:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[13:0];
                REG_ALPHA_DEFAULT: alpha_default_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    assign ucfg = '{depth_mode:    depth_mode_reg,
                    image_width:   image_width_reg,
                    image_height:  image_height_reg,
                    alpha_default: alpha_default_reg};

    // Unpack stage: palette writes go straight to the RAM, data bytes become pixel requests,
    // one per cycle while the queue has room, palette ones with their read in the same cycle.
    bpu_unpack #(
        .MAX_WIDTH       (MAX_WIDTH),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_unpack (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (ucfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .palette_slot (palette_slot),
        .palette_word (palette_word),
        .data_byte    (data_byte),
        .pal_we       (pal_we),
        .pal_waddr    (pal_waddr),
        .pal_wdata    (pal_wdata),
        .pal_re       (pal_re),
        .pal_raddr    (pal_raddr),
        .can_issue    (can_issue),
        .req_valid    (req_valid),
        .req          (req)
    );

    // Palette store: writes and reads come from the same in-order stage, so a read
    // always sees every earlier write and the two never collide in one cycle.
    bpu_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    // Format stage and output queue; hold issue back when the queue would overflow
    bpu_format u_format (
        .clk         (clk),
        .rst_n       (rst_n),
        .out_format  (out_format_reg),
        .req_valid   (req_valid),
        .req         (req),
        .pal_rdata   (pal_rdata),
        .can_issue   (can_issue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_value (pixel_value),
        .pixel_bytes (pixel_bytes),
        .row_end     (row_end),
        .frame_end   (frame_end),
        .last_of_run (last_of_run)
    );

    // A palette write and a palette read never share a cycle
    a_pal_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(pal_we && pal_re))
        else $error("palette write and read in the same cycle");

    // A palette read only happens for an issued pixel, and that pixel reaches the queue
    a_read_issue: assert property (@(posedge clk) disable iff (!rst_n)
        pal_re |-> req_valid)
        else $error("palette read without a pixel request");

    // Frame end marks only the last pixel of a row
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame end without row end");

    // Byte count follows one of the three formats
    a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_bytes == BYTES_RGB32 || pixel_bytes == BYTES_RGB24 ||
                       pixel_bytes == BYTES_RGB565))
        else $error("bad pixel byte count");

endmodule
